>>> rtl/wvp_pkg.sv
package wvp_pkg;

    localparam int WAVES      = 128;
    localparam int TABLE_LEN  = 256;
    localparam int MAX_VOLUME = 255;
    localparam int PAN_CENTER = 6;
    localparam int PAN_RIGHT  = 12;

    localparam int WAVE_W    = $clog2(WAVES);
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int ADDR_W    = WAVE_W + IDX_W;
    localparam int MEM_DEPTH = WAVES * TABLE_LEN;

    localparam int SMP_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int PHASE_W = IDX_W + FRAC_W;
    localparam int VOL_W   = 8;
    localparam int PAN_W   = 4;
    localparam int NUM_W   = $clog2(PAN_RIGHT + 1);
    localparam int GAIN_W  = VOL_W + NUM_W;

    localparam int VOL_RESET = 255;

    // interpolated value is s1*2^16 + (s2-s1)*f, fits a signed 32-bit word
    localparam int INTERP_W = SMP_W + FRAC_W;
    localparam int MAG_W    = INTERP_W;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int X_W      = PROD_W - FRAC_W;

    // remaining divisor after the 2^16 shift, done by reciprocal multiply
    localparam int DEN       = MAX_VOLUME * PAN_CENTER;
    localparam int RECIP_SH  = X_W + 1;
    localparam int RECIP_W   = RECIP_SH;
    localparam longint unsigned RECIP_L = (64'd1 << RECIP_SH) / DEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int Q_W       = X_W - $clog2(DEN) + 1;

    localparam int SMP_POS_MAX = 2 ** (SMP_W - 1) - 1;
    localparam int SMP_NEG_MAG = 2 ** (SMP_W - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PHASE_W;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_SAMPLE    = 2'd1,
        CMD_PHASE_CLR = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SAMPLE,
        OP_PHASE_CLR
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_WAVE_SELECT = 2'd1,
        REG_VOLUME      = 2'd2,
        REG_PAN         = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERP,
        ST_MAG,
        ST_SCALE,
        ST_RECIP,
        ST_FIX,
        ST_OUT
    } t_vstate;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [WAVE_W-1:0]  wave_select;
        logic [VOL_W-1:0]   volume;
        logic [PAN_W-1:0]   pan;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [SMP_W-1:0]  value;
    } t_op_item;

    typedef struct packed {
        logic     valid;
        t_op_item item;
    } t_q_head;

endpackage

>>> rtl/wvp_if.sv
interface wvp_in_if;
    import wvp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [WAVE_W-1:0]        table_wave;
    logic [IDX_W-1:0]         table_index;
    logic signed [SMP_W-1:0]  table_value;

    modport source (output valid, output cmd, output table_wave, output table_index,
                    output table_value, input ready);
    modport sink   (input valid, input cmd, input table_wave, input table_index,
                    input table_value, output ready);
endinterface

interface wvp_out_if;
    import wvp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  left_sample;
    logic signed [SMP_W-1:0]  right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

>>> rtl/wavetable_voice_with_pan.sv
// One wavetable voice with linear interpolation, volume and stereo pan.
// i_cmd_ch takes command words (valid/ready): write a table entry, clear the
// phase, or generate one stereo sample; an unused code is taken and dropped.
// Only a generate command produces a word on o_smp_ch (left/right sample).
// Registers (phase step, wave, volume, pan) are written through i_cfg_we /
// i_cfg_idx / i_cfg_data; the user must write them only while the voice is
// idle, which the block itself does not enforce. A four-word queue sits
// between the command port and the sample engine, so commands keep flowing
// in while the engine works or the output is held. Table writes and phase
// clears retire straight from the idle state. A sample walks a seven-step
// sequence in the engine (table read, interpolate, magnitude, volume/pan
// multiply, reciprocal divide, correction, output). The multiply chain runs
// through one shared engine, which takes no new command from the queue until
// the sample has gone into the output register.
// The output word sits in a register; while the receiver stalls the engine
// holds its finished sample and the queue fills, then i_cmd_ch.ready drops.
// Reset (synchronous, active low) clears the phase, the queue and the output
// valid, and loads the register defaults; the wave table is not cleared.
module wavetable_voice_with_pan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wvp_in_if.sink                           i_cmd_ch,
    wvp_out_if.source                        o_smp_ch,
    input  logic                             i_cfg_we,
    input  logic [wvp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wvp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wvp_pkg::*;

    t_cfg    r_cfg;
    t_q_head head;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step  <= PHASE_W'(1 << FRAC_W);
            r_cfg.wave_select <= '0;
            r_cfg.volume      <= VOL_W'(VOL_RESET);
            r_cfg.pan         <= PAN_W'(PAN_CENTER);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PHASE_STEP:  r_cfg.phase_step  <= i_cfg_data[PHASE_W-1:0];
                REG_WAVE_SELECT: r_cfg.wave_select <= i_cfg_data[WAVE_W-1:0];
                REG_VOLUME:      r_cfg.volume      <= i_cfg_data[VOL_W-1:0];
                REG_PAN:         r_cfg.pan         <= i_cfg_data[PAN_W-1:0];
            endcase
        end
    end

    wvp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (i_cmd_ch),
        .i_pop    (pop),
        .o_head   (head)
    );

    wvp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .o_pop    (pop),
        .o_smp_ch (o_smp_ch)
    );

endmodule

>>> rtl/wvp_front.sv
module wvp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wvp_in_if.sink           i_cmd_ch,
    input  logic             i_pop,
    output wvp_pkg::t_q_head o_head
);
    import wvp_pkg::*;

    t_op_item              r_fifo [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   r_wr_ptr;
    logic [FQ_PTR_W-1:0]   r_rd_ptr;
    logic [FQ_PTR_W:0]     r_count;

    t_op_item n_item;
    logic     keep;
    logic     push;

    assign i_cmd_ch.ready = (r_count != (FQ_PTR_W + 1)'(FQ_DEPTH));

    always_comb begin
        n_item.addr  = {i_cmd_ch.table_wave, i_cmd_ch.table_index};
        n_item.value = i_cmd_ch.table_value;
        n_item.op    = OP_WRITE;
        keep         = 1'b1;
        unique case (t_cmd'(i_cmd_ch.cmd))
            CMD_WRITE:     n_item.op = OP_WRITE;
            CMD_SAMPLE:    n_item.op = OP_SAMPLE;
            CMD_PHASE_CLR: n_item.op = OP_PHASE_CLR;
            CMD_NONE:      keep = 1'b0;   // unused code: taken and dropped
        endcase
    end

    assign push = i_cmd_ch.valid && i_cmd_ch.ready && keep;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FQ_PTR_W'(1);
            end
            unique case ({push, i_pop})
                2'b10:   r_count <= r_count + (FQ_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (FQ_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_fifo[r_rd_ptr];

endmodule

>>> rtl/wvp_back.sv
module wvp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wvp_pkg::t_cfg    i_cfg,
    input  wvp_pkg::t_q_head i_head,
    output logic             o_pop,
    wvp_out_if.source        o_smp_ch
);
    import wvp_pkg::*;

    function automatic logic [SMP_W-1:0] sat_sample(logic neg, logic [Q_W-1:0] q);
        logic [SMP_W-1:0] res;
        if (neg) begin
            if (q >= Q_W'(SMP_NEG_MAG)) begin
                res = SMP_W'(SMP_NEG_MAG);
            end else begin
                res = SMP_W'(-q);
            end
        end else begin
            if (q > Q_W'(SMP_POS_MAX)) begin
                res = SMP_W'(SMP_POS_MAX);
            end else begin
                res = SMP_W'(q);
            end
        end
        return res;
    endfunction

    // wave store
    logic [SMP_W-1:0]        r_mem [MEM_DEPTH];
    logic signed [SMP_W-1:0] r_s1;
    logic signed [SMP_W-1:0] r_s2;
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_W-1:0]       rd_addr_a;
    logic [ADDR_W-1:0]       rd_addr_b;

    t_vstate               r_state, n_state;
    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [FRAC_W-1:0]     r_frac;
    logic [GAIN_W-1:0]     r_gain_l, r_gain_r;
    logic signed [INTERP_W-1:0] r_interp;
    logic                  r_neg;
    logic [MAG_W-1:0]      r_mag;
    logic [X_W-1:0]        r_x_l, r_x_r;
    logic [Q_W-1:0]        r_q_l, r_q_r;
    logic                  r_out_valid;
    logic [SMP_W-1:0]      r_out_l, r_out_r;
    logic                  out_push;

    logic [IDX_W-1:0]      pos;
    logic [NUM_W-1:0]      lnum, rnum;
    logic signed [SMP_W:0] diff;
    logic signed [INTERP_W+1:0] diff_mul;
    logic signed [INTERP_W+1:0] interp_w;
    logic [PROD_W-1:0]     prod_l, prod_r;
    logic [X_W+RECIP_W-1:0] qm_l, qm_r;
    logic [X_W-1:0]        rem_l, rem_r;

    assign pos       = r_phase[PHASE_W-1 -: IDX_W];
    assign rd_addr_a = {i_cfg.wave_select, pos};
    assign rd_addr_b = {i_cfg.wave_select, pos + IDX_W'(1)};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.item.addr] <= i_head.item.value;
        end
        if (mem_re) begin
            r_s1 <= r_mem[rd_addr_a];
            r_s2 <= r_mem[rd_addr_b];
        end
    end

    // pan numerators, denominator PAN_CENTER
    always_comb begin
        lnum = NUM_W'(PAN_CENTER);
        rnum = NUM_W'(PAN_CENTER);
        if (int'(i_cfg.pan) < PAN_CENTER) begin
            rnum = NUM_W'(i_cfg.pan);
        end else if (int'(i_cfg.pan) > PAN_CENTER) begin
            if (int'(i_cfg.pan) > PAN_RIGHT) begin
                lnum = '0;
            end else begin
                lnum = NUM_W'(PAN_RIGHT - int'(i_cfg.pan));
            end
        end
    end

    // s1*2^16 + (s2-s1)*f
    assign diff     = {r_s2[SMP_W-1], r_s2} - {r_s1[SMP_W-1], r_s1};
    assign diff_mul = diff * $signed({1'b0, r_frac});
    assign interp_w = ((INTERP_W + 2)'(r_s1) <<< FRAC_W) + diff_mul;

    assign prod_l = PROD_W'(r_mag) * PROD_W'(r_gain_l);
    assign prod_r = PROD_W'(r_mag) * PROD_W'(r_gain_r);

    assign qm_l = (X_W + RECIP_W)'(r_x_l) * (X_W + RECIP_W)'(RECIP);
    assign qm_r = (X_W + RECIP_W)'(r_x_r) * (X_W + RECIP_W)'(RECIP);

    // estimate is exact or one low
    assign rem_l = r_x_l - X_W'(r_q_l) * X_W'(DEN);
    assign rem_r = r_x_r - X_W'(r_q_r) * X_W'(DEN);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_push = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.item.op)
                        OP_WRITE:     mem_we = 1'b1;
                        OP_PHASE_CLR: n_phase = '0;
                        OP_SAMPLE: begin
                            mem_re  = 1'b1;
                            n_phase = r_phase + i_cfg.phase_step;
                            n_state = ST_INTERP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INTERP: n_state = ST_MAG;
            ST_MAG:    n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_RECIP;
            ST_RECIP:  n_state = ST_FIX;
            ST_FIX:    n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || o_smp_ch.ready) begin
                    out_push = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (mem_re) begin
                    r_frac   <= r_phase[FRAC_W-1:0];
                    r_gain_l <= GAIN_W'(i_cfg.volume) * GAIN_W'(lnum);
                    r_gain_r <= GAIN_W'(i_cfg.volume) * GAIN_W'(rnum);
                end
            end
            ST_INTERP: r_interp <= interp_w[INTERP_W-1:0];
            ST_MAG: begin
                r_neg <= r_interp[INTERP_W-1];
                r_mag <= r_interp[INTERP_W-1] ? MAG_W'(-r_interp) : MAG_W'(r_interp);
            end
            ST_SCALE: begin
                r_x_l <= prod_l[PROD_W-1:FRAC_W];
                r_x_r <= prod_r[PROD_W-1:FRAC_W];
            end
            ST_RECIP: begin
                r_q_l <= qm_l[RECIP_SH +: Q_W];
                r_q_r <= qm_r[RECIP_SH +: Q_W];
            end
            ST_FIX: begin
                if (rem_l >= X_W'(DEN)) begin
                    r_q_l <= r_q_l + Q_W'(1);
                end
                if (rem_r >= X_W'(DEN)) begin
                    r_q_r <= r_q_r + Q_W'(1);
                end
            end
            ST_OUT: begin
                if (out_push) begin
                    r_out_l <= sat_sample(r_neg, r_q_l);
                    r_out_r <= sat_sample(r_neg, r_q_r);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (out_push) begin
                r_out_valid <= 1'b1;
            end else if (o_smp_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_smp_ch.valid        = r_out_valid;
    assign o_smp_ch.left_sample  = r_out_l;
    assign o_smp_ch.right_sample = r_out_r;

endmodule
